// ----- sv/slotted_page_item_store_assert.svh -----
// Assertion macros for the slotted page item store checker.
// Depends on nothing; included by spis_checker.sv.
`ifndef SLOTTED_PAGE_ITEM_STORE_ASSERT_SVH
`define SLOTTED_PAGE_ITEM_STORE_ASSERT_SVH
// same-cycle implication, disabled in reset
`define SPIS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slotted page store check failed");
// next-cycle implication, disabled in reset
`define SPIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slotted page store check failed");
`endif

// ----- sv/spis_pkg.sv -----
// Package for the slotted page item store: codes, defaults, cell command type.
// Used by the top level, the slot cells and the checker.
`default_nettype none
package spis_pkg;
   localparam int PAGE_BYTES_DEF   = 4096;
   localparam int HEADER_BYTES_DEF = 24;
   localparam int MAX_SLOTS_DEF    = 256;
   localparam int SLOT_BYTES       = 4;
   localparam int CMP_W            = 12;   // slot compares, covers up to 4095
   localparam int OFF_MAX_W        = 16;   // widest page offset
   localparam int LEN_W            = 12;

   localparam logic [2:0] REQ_INIT  = 3'd0;
   localparam logic [2:0] REQ_PUT   = 3'd1;
   localparam logic [2:0] REQ_WRITE = 3'd2;
   localparam logic [2:0] REQ_READ  = 3'd3;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_BAD_SLOT     = 3'd1;
   localparam logic [2:0] ST_NO_SPACE     = 3'd2;
   localparam logic [2:0] ST_LEN_MISMATCH = 3'd3;
   localparam logic [2:0] ST_INDEX_RANGE  = 3'd4;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_EXEC, S_RESP
   } state_type;

   typedef struct packed {
      logic                 wr;
      logic                 shift;
      logic [CMP_W-1:0]     target;
      logic [OFF_MAX_W-1:0] off;
      logic [LEN_W-1:0]     len;
   } cell_cmd_type;
endpackage
`default_nettype wire

// ----- sv/slotted_page_item_store.sv -----
// Slotted page item store. Items are reserved downward from a top mark that
// starts at PAGE_BYTES; slot entries (offset, length) grow upward after the
// header. Each request beat on req_* gives exactly one response beat on
// rsp_*. A request goes through accept, slot lookup across the cell row,
// execute and response load, which waits while the last response is held;
// the next request is taken no sooner than the cycle after that load.
// The slot array is a row of MAX_SLOTS cells; an insert shifts all later
// entries up one together, each cell taking its lower neighbor.
// Page bytes live in a single-port-write RAM. After reset and after every
// init request the RAM is cleared one byte a cycle, all PAGE_BYTES bytes, during
// which req_tready stays low. Overwritten item space is never reclaimed.
// Depends on spis_pkg, spis_cell and spis_ram.
`default_nettype none
module slotted_page_item_store #(
   parameter int PAGE_BYTES   = spis_pkg::PAGE_BYTES_DEF,
   parameter int HEADER_BYTES = spis_pkg::HEADER_BYTES_DEF,
   parameter int MAX_SLOTS    = spis_pkg::MAX_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // slot[8:0], overwrite[9], item_length[21:10], byte_index[33:22],
   // data_byte[41:34], zero[47:42]
   input  wire logic [47:0] req_tdata,
   // req_type[2:0]
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[2:0], slot_used[11:3], read_byte[19:12], item_offset[32:20],
   // stored_length[44:33], free_bytes[57:45], zero[63:58]
   output logic [63:0]      rsp_tdata
);
   localparam int TOP_W = $clog2(PAGE_BYTES + 1);
   localparam int AW    = $clog2(PAGE_BYTES);
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int EW0   = (TOP_W > CNT_W + 3) ? TOP_W : CNT_W + 3;
   localparam int EW    = ((EW0 > 13) ? EW0 : 13) + 1;
   localparam int CW    = spis_pkg::CMP_W;
   localparam int LW    = spis_pkg::LEN_W;

   spis_pkg::state_type state_ff, state_in;

   // latched request
   logic [2:0]  typ_ff;
   logic [8:0]  slot_ff;
   logic        ovw_ff;
   logic [11:0] len_ff;
   logic [11:0] bidx_ff;
   logic [7:0]  dat_ff;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [TOP_W-1:0] top_ff, top_in;
   logic [AW-1:0]    clr_ff, clr_in;

   // looked-up slot entry
   logic [TOP_W-1:0] sel_off_ff, sel_off;
   logic [LW-1:0]    sel_len_ff, sel_len;

   // execute results
   logic [2:0]  res_status_ff, res_status_in;
   logic [8:0]  res_used_ff, res_used_in;
   logic [12:0] res_off_ff, res_off_in;
   logic [11:0] res_len_ff, res_len_in;
   logic        rd_ok_ff, rd_ok_in;
   logic        init_ff, init_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   spis_pkg::cell_cmd_type cmd;
   logic [TOP_W-1:0] cell_off [MAX_SLOTS];
   logic [LW-1:0]    cell_len [MAX_SLOTS];

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   // arithmetic
   logic [EW-1:0] arr_end, free_w, limit, target, need, pos, slot_w, cnt_w;
   logic          grows, load_rsp;

   // ---------------- slot cell row ----------------
   for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
      if (g == 0) begin : g_first
         spis_cell #(.IDX(g), .OFF_W(TOP_W)) u_cell (
            .clock(clock), .cmd(cmd),
            .prev_off('0), .prev_len('0),
            .off_ff(cell_off[g]), .len_ff(cell_len[g]));
      end else begin : g_rest
         spis_cell #(.IDX(g), .OFF_W(TOP_W)) u_cell (
            .clock(clock), .cmd(cmd),
            .prev_off(cell_off[g-1]), .prev_len(cell_len[g-1]),
            .off_ff(cell_off[g]), .len_ff(cell_len[g]));
      end
   end

   // one-hot select of the addressed slot
   always_comb begin
      sel_off = '0;
      sel_len = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (CW'(i + 1) == CW'(slot_ff)) begin
            sel_off = sel_off | cell_off[i];
            sel_len = sel_len | cell_len[i];
         end
      end
   end

   spis_ram #(.DEPTH(PAGE_BYTES), .AW(AW)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .re(ram_re), .raddr(ram_raddr), .rdata_ff(ram_rdata));

   // free space from current count and top mark, put target and size, byte position
   always_comb begin
      cnt_w   = EW'(cnt_ff);
      slot_w  = EW'(slot_ff);
      arr_end = EW'(HEADER_BYTES) + (cnt_w << 2);
      free_w  = (EW'(top_ff) >= arr_end) ? EW'(top_ff) - arr_end : '0;
      limit   = cnt_w + EW'(1);
      target  = (slot_ff != '0) ? slot_w : limit;
      grows   = !ovw_ff || (target == limit);
      need    = EW'(len_ff) + (grows ? EW'(spis_pkg::SLOT_BYTES) : '0);
      pos     = EW'(sel_off_ff) + EW'(bidx_ff);
   end

   assign load_rsp   = (state_ff == spis_pkg::S_RESP) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == spis_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- control ----------------
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      top_in        = top_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_used_in   = res_used_ff;
      res_off_in    = res_off_ff;
      res_len_in    = res_len_ff;
      rd_ok_in      = rd_ok_ff;
      init_in       = init_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      cmd           = '0;
      cmd.target    = CW'(target);
      cmd.off       = spis_pkg::OFF_MAX_W'(EW'(top_ff) - EW'(len_ff));
      cmd.len       = len_ff;
      ram_we        = 1'b0;
      ram_waddr     = clr_ff;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = AW'(pos);
      unique case (state_ff)
         spis_pkg::S_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(PAGE_BYTES - 1)) begin
               clr_in   = '0;
               state_in = spis_pkg::S_IDLE;
            end
         end
         spis_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = spis_pkg::S_LOOK;
            end
         end
         spis_pkg::S_LOOK: begin
            state_in = spis_pkg::S_EXEC;
         end
         spis_pkg::S_EXEC: begin
            res_status_in = spis_pkg::ST_OK;
            res_used_in   = '0;
            res_off_in    = '0;
            res_len_in    = '0;
            rd_ok_in      = 1'b0;
            init_in       = 1'b0;
            state_in      = spis_pkg::S_RESP;
            unique case (typ_ff)
               spis_pkg::REQ_INIT: begin
                  cnt_in  = '0;
                  top_in  = TOP_W'(PAGE_BYTES);
                  init_in = 1'b1;
               end
               spis_pkg::REQ_PUT: begin
                  res_used_in = 9'(target);
                  if (target > limit) begin
                     res_status_in = spis_pkg::ST_BAD_SLOT;
                  end else if ((grows && cnt_w >= EW'(MAX_SLOTS)) || need > free_w) begin
                     res_status_in = spis_pkg::ST_NO_SPACE;
                  end else begin
                     top_in     = TOP_W'(EW'(top_ff) - EW'(len_ff));
                     cmd.wr     = 1'b1;
                     cmd.shift  = grows;
                     res_off_in = 13'(EW'(top_ff) - EW'(len_ff));
                     res_len_in = len_ff;
                     if (grows) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
               end
               spis_pkg::REQ_WRITE, spis_pkg::REQ_READ: begin
                  res_used_in = slot_ff;
                  if (slot_ff == '0 || slot_w > cnt_w) begin
                     res_status_in = spis_pkg::ST_BAD_SLOT;
                  end else begin
                     res_off_in = 13'(sel_off_ff);
                     res_len_in = sel_len_ff;
                     if (typ_ff == spis_pkg::REQ_WRITE && len_ff != sel_len_ff) begin
                        res_status_in = spis_pkg::ST_LEN_MISMATCH;
                     end else if (bidx_ff >= sel_len_ff || pos >= EW'(PAGE_BYTES)) begin
                        res_status_in = spis_pkg::ST_INDEX_RANGE;
                     end else if (typ_ff == spis_pkg::REQ_WRITE) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(pos);
                        ram_wdata = dat_ff;
                     end else begin
                        ram_re   = 1'b1;
                        rd_ok_in = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         spis_pkg::S_RESP: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, 13'(free_w), res_len_ff, res_off_ff,
                               (rd_ok_ff ? ram_rdata : 8'd0), res_used_ff, res_status_ff};
               state_in     = init_ff ? spis_pkg::S_CLEAR : spis_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spis_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spis_pkg::S_CLEAR;
         cnt_ff       <= '0;
         top_ff       <= TOP_W'(PAGE_BYTES);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         init_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         top_ff       <= top_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         init_ff      <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         typ_ff  <= req_tuser;
         slot_ff <= req_tdata[8:0];
         ovw_ff  <= req_tdata[9];
         len_ff  <= req_tdata[21:10];
         bidx_ff <= req_tdata[33:22];
         dat_ff  <= req_tdata[41:34];
      end
      if (state_ff == spis_pkg::S_LOOK) begin
         sel_off_ff <= sel_off;
         sel_len_ff <= sel_len;
      end
      res_status_ff <= res_status_in;
      res_used_ff   <= res_used_in;
      res_off_ff    <= res_off_in;
      res_len_ff    <= res_len_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_data_ff   <= rsp_data_in;
   end
endmodule
`default_nettype wire

// ----- sv/spis_cell.sv -----
// One slot entry of the slot array chain: holds an item offset and length.
// Depends on spis_pkg.
`default_nettype none
module spis_cell #(
   parameter int IDX   = 0,
   parameter int OFF_W = 13
) (
   input  wire logic                    clock,
   input  wire spis_pkg::cell_cmd_type  cmd,
   input  wire logic [OFF_W-1:0]        prev_off,
   input  wire logic [spis_pkg::LEN_W-1:0] prev_len,
   output logic [OFF_W-1:0]             off_ff,
   output logic [spis_pkg::LEN_W-1:0]   len_ff
);
   logic [OFF_W-1:0]           off_in;
   logic [spis_pkg::LEN_W-1:0] len_in;

   always_comb begin
      off_in = off_ff;
      len_in = len_ff;
      if (cmd.wr && (spis_pkg::CMP_W'(IDX + 1) == cmd.target)) begin
         off_in = cmd.off[OFF_W-1:0];
         len_in = cmd.len;
      end else if (cmd.shift && (spis_pkg::CMP_W'(IDX) >= cmd.target)) begin
         off_in = prev_off;   // take the lower neighbor's entry
         len_in = prev_len;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      len_ff <= len_in;
   end
endmodule
`default_nettype wire

// ----- sv/spis_ram.sv -----
// Page byte memory: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none
module spis_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [7:0]    wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic [7:0]         rdata_ff
);
   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

// ----- sv/spis_checker.sv -----
// Port-level checks for the slotted page item store, bound to the top level.
// Depends on spis_pkg, slotted_page_item_store_assert.svh and the top level.
`default_nettype none
`include "slotted_page_item_store_assert.svh"
module spis_checker #(
   parameter int PAGE_BYTES   = spis_pkg::PAGE_BYTES_DEF,
   parameter int HEADER_BYTES = spis_pkg::HEADER_BYTES_DEF
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_rbyte;
   logic [31:0] rsp_free;

   assign rsp_status = rsp_tdata[2:0];
   assign rsp_rbyte  = rsp_tdata[19:12];
   assign rsp_free   = 32'(rsp_tdata[57:45]);

   `SPIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `SPIS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `SPIS_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, rsp_status <= spis_pkg::ST_INDEX_RANGE)
   `SPIS_ASSERT_NOW(a_rbyte_zero, clock, reset, rsp_tvalid && rsp_status != spis_pkg::ST_OK, rsp_rbyte == 8'd0)
   `SPIS_ASSERT_NOW(a_free_bound, clock, reset, rsp_tvalid, rsp_free <= 32'(PAGE_BYTES - HEADER_BYTES))
endmodule

bind slotted_page_item_store spis_checker #(
   .PAGE_BYTES(PAGE_BYTES), .HEADER_BYTES(HEADER_BYTES)
) u_spis_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

// ----- bench/slotted_page_item_store_tb.sv -----
// Self-checking bench for the slotted page item store: a driver and a monitor
// around the block, with a behavioral page model that predicts every response.
// Depends on spis_pkg and slotted_page_item_store.
`default_nettype none
module slotted_page_item_store_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PG   = 4096;
   localparam int HDR  = 24;
   localparam int NSLT = 256;
   localparam logic [2:0] REQ_NOP = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [8:0]  slot;
      logic        ovw;
      logic [11:0] len;
      logic [11:0] bidx;
      logic [7:0]  dbyte;
   } page_req_type;

   // last member sits in the lowest bits, matching rsp_tdata
   typedef struct packed {
      logic [12:0] free_bytes;
      logic [11:0] stored_length;
      logic [12:0] item_offset;
      logic [7:0]  read_byte;
      logic [8:0]  slot_used;
      logic [2:0]  status;
   } page_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   slotted_page_item_store DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // shadow page state
   logic [7:0]  pg_mem [PG];
   logic [12:0] sl_off [NSLT];
   logic [11:0] sl_len [NSLT];
   int          sl_cnt;
   int          top_mark;

   page_req_type pending_reqs[$];
   page_rsp_type expected_rsps[$];
   int errors = 0;
   int send_idle_pct = 21;
   int recv_idle_pct = 71;
   logic hold_active = 1'b0;   // forced receiver stall in progress

   function automatic int page_free();
      int lo;
      lo = HDR + sl_cnt * 4;
      return top_mark >= lo ? top_mark - lo : 0;
   endfunction

   function automatic void page_clear();
      for (int i = 0; i < PG; i++) pg_mem[i] = 8'd0;
      for (int i = 0; i < NSLT; i++) begin
         sl_off[i] = '0;
         sl_len[i] = '0;
      end
      sl_cnt = 0;
      top_mark = PG;
   endfunction

   // apply one request to the shadow page, return its response
   function automatic page_rsp_type page_apply(page_req_type r);
      page_rsp_type o;
      int limit, tgt, need, s, pos;
      bit grows;
      o = '0;
      o.status = spis_pkg::ST_OK;
      if (r.kind == spis_pkg::REQ_INIT) begin
         page_clear();
      end else if (r.kind == spis_pkg::REQ_PUT) begin
         limit = sl_cnt + 1;
         tgt = r.slot != 0 ? int'(r.slot) : limit;
         o.slot_used = 9'(tgt);
         if (tgt > limit) begin
            o.status = spis_pkg::ST_BAD_SLOT;
         end else begin
            grows = !r.ovw || tgt == limit;
            need = int'(r.len) + (grows ? 4 : 0);
            if ((grows && sl_cnt >= NSLT) || need > page_free()) begin
               o.status = spis_pkg::ST_NO_SPACE;
            end else begin
               top_mark -= int'(r.len);
               if (grows) begin
                  for (int i = sl_cnt; i >= tgt; i--) begin
                     sl_off[i] = sl_off[i-1];
                     sl_len[i] = sl_len[i-1];
                  end
                  sl_cnt++;
               end
               sl_off[tgt-1] = 13'(top_mark);
               sl_len[tgt-1] = r.len;
               o.item_offset = 13'(top_mark);
               o.stored_length = r.len;
            end
         end
      end else if (r.kind == spis_pkg::REQ_WRITE || r.kind == spis_pkg::REQ_READ) begin
         o.slot_used = r.slot;
         if (r.slot == 0 || int'(r.slot) > sl_cnt) begin
            o.status = spis_pkg::ST_BAD_SLOT;
         end else begin
            s = int'(r.slot) - 1;
            o.item_offset = sl_off[s];
            o.stored_length = sl_len[s];
            pos = int'(sl_off[s]) + int'(r.bidx);
            if (r.kind == spis_pkg::REQ_WRITE && r.len != sl_len[s])
               o.status = spis_pkg::ST_LEN_MISMATCH;
            else if (r.bidx >= sl_len[s] || pos >= PG) o.status = spis_pkg::ST_INDEX_RANGE;
            else if (r.kind == spis_pkg::REQ_WRITE) pg_mem[pos] = r.dbyte;
            else o.read_byte = pg_mem[pos];
         end
      end
      o.free_bytes = 13'(page_free());
      return o;
   endfunction

   // driver: one beat per handshake, predicts on acceptance
   always @(posedge clock) begin
      page_req_type r;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            r = pending_reqs.pop_front();
            expected_rsps.push_back(page_apply(r));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               r = pending_reqs[0];
               req_tvalid <= 1'b1;
               req_tuser  <= r.kind;
               req_tdata  <= {6'd0, r.dbyte, r.bidx, r.len, r.ovw, r.slot};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each response beat against the oldest prediction
   always @(posedge clock) begin
      page_rsp_type a, e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            a = rsp_tdata[57:0];
            if (expected_rsps.size() == 0) begin
               $error("unexpected response beat %h", rsp_tdata);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (a.status != e.status) begin
                  $error("status exp %0d got %0d", e.status, a.status); errors++;
               end
               if (a.slot_used != e.slot_used) begin
                  $error("slot_used exp %0d got %0d", e.slot_used, a.slot_used); errors++;
               end
               if (a.read_byte != e.read_byte) begin
                  $error("read_byte exp %0d got %0d", e.read_byte, a.read_byte); errors++;
               end
               if (a.item_offset != e.item_offset) begin
                  $error("item_offset exp %0d got %0d", e.item_offset, a.item_offset);
                  errors++;
               end
               if (a.stored_length != e.stored_length) begin
                  $error("stored_length exp %0d got %0d", e.stored_length,
                         a.stored_length);
                  errors++;
               end
               if (a.free_bytes != e.free_bytes) begin
                  $error("free_bytes exp %0d got %0d", e.free_bytes, a.free_bytes);
                  errors++;
               end
            end
         end
         if (hold_active) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic page_req_type mk(logic [2:0] k, int sl, int ov, int ln, int bi,
                                       int db);
      page_req_type r;
      r.kind = k; r.slot = 9'(sl); r.ovw = 1'(ov); r.len = 12'(ln); r.bidx = 12'(bi);
      r.dbyte = 8'(db);
      return r;
   endfunction

   // random request biased toward valid slots of a page built so far
   function automatic page_req_type rand_req(int est_slots);
      int p, sl;
      p = $urandom_range(99);
      sl = est_slots > 0 ? $urandom_range(est_slots, 1) : 1;
      if (p < 2)
         return mk(spis_pkg::REQ_INIT, $urandom_range(511), $urandom_range(1),
                   $urandom_range(4095), $urandom_range(4095), $urandom_range(255));
      if (p < 14)
         return mk(spis_pkg::REQ_PUT,
                   ($urandom_range(3) == 0) ? 0 : $urandom_range(est_slots + 2),
                   $urandom_range(1),
                   ($urandom_range(19) == 0) ? $urandom_range(4095) : $urandom_range(40),
                   $urandom_range(4095), $urandom_range(255));
      if (p < 50)
         return mk(spis_pkg::REQ_WRITE, sl, $urandom_range(1),
                   ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(40),
                   $urandom_range(40), $urandom_range(255));
      if (p < 92)
         return mk(spis_pkg::REQ_READ, sl, $urandom_range(1), $urandom_range(4095),
                   ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(40),
                   $urandom_range(255));
      if (p < 96)
         return mk(3'(REQ_NOP + $urandom_range(3)), $urandom_range(511), $urandom_range(1),
                   $urandom_range(4095), $urandom_range(4095), $urandom_range(255));
      return mk(3'($urandom_range(3) + 1), 0 + $urandom_range(511), $urandom_range(1),
                $urandom_range(4095), $urandom_range(4095), $urandom_range(255));
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int nslots;
      page_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, each request kind, each error path
      pending_reqs.push_back(mk(REQ_NOP, 511, 1, 4095, 4095, 255));
      pending_reqs.push_back(mk(3'(REQ_NOP + 3), 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_READ, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_WRITE, 1, 0, 0, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 5, 0, 4, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 0, 0, 8, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 2, 1, 3, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 1, 0, 0, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 2, 1, 5, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_WRITE, 2, 0, 5, 4, 8'hFF));
      pending_reqs.push_back(mk(spis_pkg::REQ_WRITE, 2, 0, 4, 0, 8'hAA));
      pending_reqs.push_back(mk(spis_pkg::REQ_WRITE, 2, 0, 5, 5, 8'h11));
      pending_reqs.push_back(mk(spis_pkg::REQ_READ, 2, 1, 4095, 4, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_READ, 2, 0, 0, 4095, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_READ, 1, 0, 0, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 0, 0, 4095, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 9, 0, 4095, 4095, 255));
      pending_reqs.push_back(mk(spis_pkg::REQ_INIT, 511, 1, 4095, 4095, 255));
      pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 0, 0, 4068, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_WRITE, 1, 0, 4068, 4067, 8'h5A));
      pending_reqs.push_back(mk(spis_pkg::REQ_READ, 1, 0, 0, 4067, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_INIT, 0, 0, 0, 0, 0));
      // fill every slot with empty items to reach the slot limit
      for (int i = 0; i < NSLT + 1; i++)
         pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 256, 1, 2, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 256, 0, 0, 0, 0));
      pending_reqs.push_back(mk(spis_pkg::REQ_INIT, 0, 0, 0, 0, 0));
      wait_drained();

      // receiver stalls long while sender keeps offering
      send_idle_pct = 0;
      fork
         begin
            hold_active = 1'b1;
            repeat (300) @(posedge clock);
            hold_active = 1'b0;
         end
      join_none
      for (int i = 0; i < 40; i++) pending_reqs.push_back(mk(spis_pkg::REQ_PUT, 0, 0, 6, 0, 0));
      wait_drained();
      send_idle_pct = 21;

      // random phases: idle mix changes each phase
      nslots = 40;
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle_pct = 71; recv_idle_pct = 21; end
         if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         for (int i = 0; i < 460; i++) begin
            page_req_type r;
            r = rand_req(nslots);
            if (r.kind == spis_pkg::REQ_INIT) nslots = 0;
            if (r.kind == spis_pkg::REQ_PUT && nslots < 60) nslots++;
            pending_reqs.push_back(r);
         end
         wait_drained();
      end
      repeat (50) @(posedge clock);
      if (errors == 0) $display("** slotted_page_item_store: PASSED **");
      else $display("** slotted_page_item_store: FAILED **");
      $finish;
   end

   initial begin
      #100ms;
      $display("** slotted_page_item_store: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
